// ===== rtl/core/msd_pkg.sv =====
`default_nettype none

package msd_pkg;

    localparam int LEVEL_W    = 4;
    localparam int CNT_W      = 8;
    localparam int IDX_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int SWITCHES_DEFAULT = 4;

    localparam logic [CNT_W-1:0] DEBOUNCE_RST = 8'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_ENABLE  = 2'd1;

    // item kinds
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef struct packed {
        logic               is_tick;
        logic [LEVEL_W-1:0] sample;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/msd_front.sv =====
`default_nettype none

module msd_front #(
    parameter int SWITCHES = msd_pkg::SWITCHES_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_func,
    input  wire logic [msd_pkg::LEVEL_W-1:0] i_raw_levels,
    output logic                             o_cmd_valid,
    output msd_pkg::t_cmd                    o_cmd,
    input  wire logic                        i_pop
);
    import msd_pkg::*;

    localparam int LANES = (SWITCHES < LEVEL_W) ? SWITCHES : LEVEL_W;
    localparam logic [LEVEL_W-1:0] LANE_MASK = LEVEL_W'((32'd1 << LANES) - 32'd1);

    // two-entry command queue
    t_cmd       r_q [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    logic       push;
    logic       pop;
    t_cmd       cmd_in;

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        cmd_in.is_tick = (i_func == FUNC_TICK);
        // samples keep only the modeled switches
        cmd_in.sample  = i_raw_levels & LANE_MASK;
    end

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/msd_back.sv =====
`default_nettype none

module msd_back #(
    parameter int SWITCHES = msd_pkg::SWITCHES_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cmd_valid,
    input  wire msd_pkg::t_cmd               i_cmd,
    output logic                             o_pop,
    input  wire logic [msd_pkg::CNT_W-1:0]   i_debounce_ticks,
    input  wire logic                        i_report_enable,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_event_valid,
    output logic [msd_pkg::IDX_W-1:0]        o_switch_index,
    output logic                             o_new_level,
    output logic [msd_pkg::LEVEL_W-1:0]      o_debounced_levels,
    output logic                             o_last
);
    import msd_pkg::*;

    localparam int LANES = (SWITCHES < LEVEL_W) ? SWITCHES : LEVEL_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic               r_state;
    logic               n_state;
    logic [CNT_W-1:0]   r_cd [0:LANES-1];
    logic [CNT_W-1:0]   n_cd [0:LANES-1];
    logic [LEVEL_W-1:0] r_last;
    logic [LEVEL_W-1:0] n_last;
    logic [LEVEL_W-1:0] r_stable;
    logic [LEVEL_W-1:0] n_stable;
    logic [LANES-1:0]   r_pend;
    logic [LANES-1:0]   n_pend;

    logic               r_o_valid;
    logic               n_o_valid;
    logic               r_o_event;
    logic               n_o_event;
    logic [IDX_W-1:0]   r_o_idx;
    logic [IDX_W-1:0]   n_o_idx;
    logic               r_o_level;
    logic               n_o_level;
    logic [LEVEL_W-1:0] r_o_levels;
    logic [LEVEL_W-1:0] n_o_levels;
    logic               r_o_last;
    logic               n_o_last;

    logic               slot_free;
    logic [LEVEL_W-1:0] changed;
    logic [LANES-1:0]   fire;
    logic [LANES-1:0]   low_bit;
    logic [IDX_W-1:0]   low_idx;
    logic [LEVEL_W-1:0] stable_fired;

    assign slot_free = !r_o_valid || !i_stall;
    assign o_pop     = (r_state == ST_IDLE) && i_cmd_valid && slot_free;

    assign changed      = i_cmd.sample ^ r_last;
    assign stable_fired = r_stable ^ LEVEL_W'(fire);
    assign low_bit      = r_pend & (~r_pend + LANES'(1));

    // a switch settles when its countdown steps from one to zero
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            fire[i] = (r_cd[i] == CNT_W'(1)) && (r_last[i] != r_stable[i]);
        end
    end

    always_comb begin
        low_idx = '0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                low_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cd       = r_cd;
        n_last     = r_last;
        n_stable   = r_stable;
        n_pend     = r_pend;
        n_o_valid  = r_o_valid && i_stall;
        n_o_event  = r_o_event;
        n_o_idx    = r_o_idx;
        n_o_level  = r_o_level;
        n_o_levels = r_o_levels;
        n_o_last   = r_o_last;

        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    if (!i_cmd.is_tick) begin
                        for (int i = 0; i < LANES; i++) begin
                            if (changed[i]) begin
                                n_cd[i] = i_debounce_ticks;
                            end
                        end
                        n_last     = i_cmd.sample;
                        n_o_valid  = 1'b1;
                        n_o_event  = 1'b0;
                        n_o_idx    = '0;
                        n_o_level  = 1'b0;
                        n_o_levels = r_stable;
                        n_o_last   = 1'b1;
                    end else begin
                        for (int i = 0; i < LANES; i++) begin
                            if (r_cd[i] != '0) begin
                                n_cd[i] = r_cd[i] - CNT_W'(1);
                            end
                        end
                        if (i_report_enable && (fire != '0)) begin
                            // events go out one per cycle while the output is not stalled, lowest switch first
                            n_pend  = fire;
                            n_state = ST_EMIT;
                        end else begin
                            n_stable   = stable_fired;
                            n_o_valid  = 1'b1;
                            n_o_event  = 1'b0;
                            n_o_idx    = '0;
                            n_o_level  = 1'b0;
                            n_o_levels = stable_fired;
                            n_o_last   = 1'b1;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_stable   = r_stable ^ LEVEL_W'(low_bit);
                    n_pend     = r_pend & ~low_bit;
                    n_o_valid  = 1'b1;
                    n_o_event  = 1'b1;
                    n_o_idx    = low_idx;
                    n_o_level  = r_last[low_idx];
                    n_o_levels = r_stable ^ LEVEL_W'(low_bit);
                    n_o_last   = ((r_pend & ~low_bit) == '0);
                    if ((r_pend & ~low_bit) == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_last    <= '0;
            r_stable  <= '0;
            r_pend    <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                r_cd[i] <= DEBOUNCE_RST;
            end
        end else begin
            r_state   <= n_state;
            r_last    <= n_last;
            r_stable  <= n_stable;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
            r_cd      <= n_cd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_event  <= n_o_event;
        r_o_idx    <= n_o_idx;
        r_o_level  <= n_o_level;
        r_o_levels <= n_o_levels;
        r_o_last   <= n_o_last;
    end

    assign o_valid            = r_o_valid;
    assign o_event_valid      = r_o_event;
    assign o_switch_index     = r_o_idx;
    assign o_new_level        = r_o_level;
    assign o_debounced_levels = r_o_levels;
    assign o_last             = r_o_last;

endmodule

`default_nettype wire

// ===== rtl/core/multi_switch_debouncer_top.sv =====
// multi-switch debouncer
// input channel: i_valid / o_stall with i_func (0 raw sample, 1 tick) and
// i_raw_levels; a transfer happens when i_valid is high and o_stall is low.
// output channel: o_valid / i_stall with the event fields, the debounced
// vector and o_last marking the final result of an item.
// the front queues up to two items; the back pulls one item at a time.
// a sample gives one plain result, held first in the queue and then in the
// back's output register. a tick is handled in the back and gives one
// result per reported event, at most min(SWITCHES,4) since only four
// switches are tracked, or one plain result when it reports no events.
// the back emits at most one result per cycle while i_stall is low, from
// its single output register. while i_stall is high over a valid result,
// the result register holds, the back waits, and the queue fills, after
// which o_stall rises.
// reset clears the queue, the debounced and sampled levels, sets every
// countdown to 5 and the registers to debounce_ticks 5, report off.
// configuration: i_cfg_we with i_cfg_idx (0 debounce_ticks, 1 report_enable)
// and i_cfg_data; write it only while the block is idle.
`default_nettype none

module multi_switch_debouncer_top #(
    parameter int SWITCHES = msd_pkg::SWITCHES_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_func,
    input  wire logic [msd_pkg::LEVEL_W-1:0]    i_raw_levels,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_event_valid,
    output logic [msd_pkg::IDX_W-1:0]           o_switch_index,
    output logic                                o_new_level,
    output logic [msd_pkg::LEVEL_W-1:0]         o_debounced_levels,
    output logic                                o_last,
    input  wire logic                           i_cfg_we,
    input  wire logic [msd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [msd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import msd_pkg::*;

    logic [CNT_W-1:0] r_debounce_ticks;
    logic             r_report_enable;
    logic             cmd_valid;
    t_cmd             cmd;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= DEBOUNCE_RST;
            r_report_enable  <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_DEBOUNCE_TICKS) begin
                r_debounce_ticks <= i_cfg_data[CNT_W-1:0];
            end else if (i_cfg_idx == REG_REPORT_ENABLE) begin
                r_report_enable <= i_cfg_data[0];
            end
        end
    end

    msd_front #(
        .SWITCHES(SWITCHES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_raw_levels(i_raw_levels),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (pop)
    );

    msd_back #(
        .SWITCHES(SWITCHES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (cmd_valid),
        .i_cmd             (cmd),
        .o_pop             (pop),
        .i_debounce_ticks  (r_debounce_ticks),
        .i_report_enable   (r_report_enable),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_event_valid     (o_event_valid),
        .o_switch_index    (o_switch_index),
        .o_new_level       (o_new_level),
        .o_debounced_levels(o_debounced_levels),
        .o_last            (o_last)
    );

endmodule

`default_nettype wire
